@@ src/table_atan2_unit_defines.svh @@
// Assertion macros shared by the atan2 block.
`ifndef TABLE_ATAN2_UNIT_DEFINES_SVH
`define TABLE_ATAN2_UNIT_DEFINES_SVH

// Check cons in the same cycle as ante.
`define TA2_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons a fixed number of cycles after ante.
`define TA2_ASSERT_AFTER(label, ante, lat, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(lat) (cons)) \
    else $error(msg);

`endif

@@ src/ta2_pkg.sv @@
package ta2_pkg;

  localparam int IN_W       = 16;
  localparam int FRAC_W     = 16;
  localparam int Z_W        = FRAC_W + 1;
  localparam int DIV_STEP   = 3;
  localparam int DIV_STAGES = (Z_W + DIV_STEP - 1) / DIV_STEP;

  localparam int TABLE_SIZE = 256;
  localparam int TS_LOG     = $clog2(TABLE_SIZE);
  localparam int SMALL_LIM  = (1 << FRAC_W) / TABLE_SIZE;
  localparam int A_W        = Z_W + TS_LOG;
  localparam int IDX_RAW_W  = A_W - FRAC_W;
  localparam int ROM_LAST   = 256;
  localparam int ROM_DEPTH  = ROM_LAST + 1;
  localparam int ROM_IDX_W  = $clog2(ROM_DEPTH);
  localparam int ROM_W      = 30;

  localparam int DIFF_W  = 22;
  localparam int PROD_W  = DIFF_W + FRAC_W;
  localparam int U_W     = ROM_W + 4;
  localparam int U_SH    = 10;
  localparam int U_HI_W  = U_W - U_SH;
  localparam int M_W     = 14;
  localparam int EST_SH  = 24;
  localparam int BASE_W  = 13;
  localparam int R_W     = 23;
  localparam int ANG_W   = 17;
  localparam int ANG_IW  = ANG_W + 1;
  localparam int LATENCY = DIV_STAGES + 9;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-3:0] REG_RANGE_MODE = '0;

  // nano-radian to Q3.13: u = v*16 + 5e8/512, angle = u / 5^9
  localparam logic [U_W-1:0]   U_OFS   = 34'd976562;
  localparam logic [20:0]      DEN     = 21'd1953125;
  localparam logic [M_W-1:0]   RECIP_M = 14'd8796;
  localparam logic [R_W-1:0]   DEN_R   = 23'd1953125;
  localparam logic [R_W-1:0]   DEN2_R  = 23'd3906250;

  localparam logic signed [ANG_IW-1:0] PI_Q13      = 18'sd25736;
  localparam logic signed [ANG_IW-1:0] HALF_PI_Q13 = 18'sd12868;
  localparam logic signed [ANG_IW-1:0] TWO_PI_Q13  = 18'sd51472;

  typedef struct packed {
    logic zero;
    logic gt;
    logic xn;
    logic yn;
  } meta_t;

  typedef struct packed {
    meta_t             meta;
    logic              tiny;
    logic [BASE_W-1:0] sval;
  } tag_t;

  localparam logic [ROM_W-1:0] ATAN_ROM [ROM_DEPTH] = '{
    30'd0, 30'd3921549, 30'd7842976, 30'd11764160,
    30'd15684990, 30'd19605330, 30'd23525070, 30'd27444090,
    30'd31362260, 30'd35279470, 30'd39195600, 30'd43110530,
    30'd47024130, 30'd50936290, 30'd54846900, 30'd58755820,
    30'd62662950, 30'd66568160, 30'd70471340, 30'd74372380,
    30'd78271140, 30'd82167520, 30'd86061410, 30'd89952670,
    30'd93841210, 30'd97726910, 30'd101609600, 30'd105489300,
    30'd109365800, 30'd113239000, 30'd117108700, 30'd120975000,
    30'd124837600, 30'd128696500, 30'd132551500, 30'd136402600,
    30'd140249600, 30'd144092400, 30'd147931000, 30'd151765200,
    30'd155594800, 30'd159419900, 30'd163240300, 30'd167055900,
    30'd170866500, 30'd174672200, 30'd178472800, 30'd182268100,
    30'd186058200, 30'd189842800, 30'd193622000, 30'd197395600,
    30'd201163400, 30'd204925500, 30'd208681800, 30'd212432000,
    30'd216176200, 30'd219914300, 30'd223646100, 30'd227371600,
    30'd231090700, 30'd234803300, 30'd238509300, 30'd242208600,
    30'd245901200, 30'd249586900, 30'd253265800, 30'd256937600,
    30'd260602400, 30'd264260000, 30'd267910400, 30'd271553500,
    30'd275189200, 30'd278817500, 30'd282438300, 30'd286051400,
    30'd289656900, 30'd293254700, 30'd296844700, 30'd300426800,
    30'd304000900, 30'd307567100, 30'd311125200, 30'd314675200,
    30'd318217000, 30'd321750600, 30'd325275800, 30'd328792700,
    30'd332301200, 30'd335801200, 30'd339292600, 30'd342775500,
    30'd346249700, 30'd349715300, 30'd353172100, 30'd356620100,
    30'd360059300, 30'd363489600, 30'd366911000, 30'd370323400,
    30'd373726800, 30'd377121100, 30'd380506400, 30'd383882500,
    30'd387249400, 30'd390607000, 30'd393955500, 30'd397294600,
    30'd400624400, 30'd403944800, 30'd407255800, 30'd410557400,
    30'd413849600, 30'd417132200, 30'd420405400, 30'd423668900,
    30'd426922900, 30'd430167300, 30'd433402100, 30'd436627200,
    30'd439842600, 30'd443048300, 30'd446244300, 30'd449430600,
    30'd452607000, 30'd455773800, 30'd458930700, 30'd462077800,
    30'd465215000, 30'd468342400, 30'd471460000, 30'd474567600,
    30'd477665400, 30'd480753200, 30'd483831200, 30'd486899200,
    30'd489957300, 30'd493005500, 30'd496043700, 30'd499071900,
    30'd502090200, 30'd505098500, 30'd508096800, 30'd511085200,
    30'd514063600, 30'd517032000, 30'd519990400, 30'd522938800,
    30'd525877200, 30'd528805600, 30'd531724100, 30'd534632500,
    30'd537531000, 30'd540419500, 30'd543298000, 30'd546166600,
    30'd549025100, 30'd551873800, 30'd554712400, 30'd557541100,
    30'd560359900, 30'd563168700, 30'd565967600, 30'd568756600,
    30'd571535700, 30'd574304800, 30'd577064100, 30'd579813500,
    30'd582553100, 30'd585282800, 30'd588002600, 30'd590712600,
    30'd593412800, 30'd596103200, 30'd598783900, 30'd601454700,
    30'd604115800, 30'd606767200, 30'd609408800, 30'd612040700,
    30'd614663000, 30'd617275500, 30'd619878400, 30'd622471700,
    30'd625055400, 30'd627629400, 30'd630193900, 30'd632748800,
    30'd635294200, 30'd637830100, 30'd640356500, 30'd642873400,
    30'd645380800, 30'd647878800, 30'd650367400, 30'd652846600,
    30'd655316500, 30'd657777000, 30'd660228200, 30'd662670100,
    30'd665102700, 30'd667526100, 30'd669940200, 30'd672345200,
    30'd674740900, 30'd677127600, 30'd679505100, 30'd681873500,
    30'd684232800, 30'd686583100, 30'd688924400, 30'd691256700,
    30'd693580000, 30'd695894300, 30'd698199800, 30'd700496400,
    30'd702784100, 30'd705063000, 30'd707333000, 30'd709594300,
    30'd711846900, 30'd714090700, 30'd716325800, 30'd718552300,
    30'd720770100, 30'd722979400, 30'd725180000, 30'd727372100,
    30'd729555700, 30'd731730700, 30'd733897400, 30'd736055500,
    30'd738205300, 30'd740346700, 30'd742479700, 30'd744604500,
    30'd746720900, 30'd748829100, 30'd750929100, 30'd753020800,
    30'd755104400, 30'd757179800, 30'd759247200, 30'd761306400,
    30'd763357600, 30'd765400800, 30'd767436000, 30'd769463300,
    30'd771482600, 30'd773494000, 30'd775497500, 30'd777493200,
    30'd779481100, 30'd781461200, 30'd783433500, 30'd785398300,
    30'd785398300
  };

endpackage

@@ src/ta2_div.sv @@
module ta2_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic [ta2_pkg::IN_W-1:0]    in_mn,
  input  logic [ta2_pkg::IN_W-1:0]    in_mx,
  input  ta2_pkg::meta_t              in_meta,
  output logic                        out_vld,
  output logic [ta2_pkg::Z_W-1:0]     out_z,
  output ta2_pkg::meta_t              out_meta
);

  typedef struct packed {
    logic [ta2_pkg::IN_W:0]   rem;
    logic [ta2_pkg::IN_W-1:0] dvs;
    logic [ta2_pkg::Z_W-1:0]  quo;
    ta2_pkg::meta_t           meta;
  } div_stage_t;

  logic       vld_r   [ta2_pkg::DIV_STAGES];
  div_stage_t stg_r   [ta2_pkg::DIV_STAGES];
  div_stage_t stg_nxt [ta2_pkg::DIV_STAGES];
  div_stage_t stin    [ta2_pkg::DIV_STAGES];

  always_comb begin
    stin[0].rem  = {1'b0, in_mn};
    stin[0].dvs  = in_mx;
    stin[0].quo  = '0;
    stin[0].meta = in_meta;
    for (int s = 1; s < ta2_pkg::DIV_STAGES; s++) begin
      stin[s] = stg_r[s-1];
    end
    for (int s = 0; s < ta2_pkg::DIV_STAGES; s++) begin
      stg_nxt[s] = stin[s];
      for (int j = 0; j < ta2_pkg::DIV_STEP; j++) begin
        if (s * ta2_pkg::DIV_STEP + j < ta2_pkg::Z_W) begin
          if (stg_nxt[s].rem >= {1'b0, stg_nxt[s].dvs}) begin
            stg_nxt[s].rem = stg_nxt[s].rem - {1'b0, stg_nxt[s].dvs};
            stg_nxt[s].quo[ta2_pkg::Z_W-1-(s*ta2_pkg::DIV_STEP+j)] = 1'b1;
          end
          stg_nxt[s].rem = stg_nxt[s].rem << 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < ta2_pkg::DIV_STAGES; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else begin
      vld_r[0] <= in_vld;
      for (int s = 1; s < ta2_pkg::DIV_STAGES; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < ta2_pkg::DIV_STAGES; s++) begin
      stg_r[s] <= stg_nxt[s];
    end
  end

  assign out_vld  = vld_r[ta2_pkg::DIV_STAGES-1];
  assign out_z    = stg_r[ta2_pkg::DIV_STAGES-1].quo;
  assign out_meta = stg_r[ta2_pkg::DIV_STAGES-1].meta;

endmodule

@@ src/table_atan2_unit.sv @@
// Throughput: one transfer per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the 17-bit ratio divider (6 stages of up to 3 quotient bits) plus
// ROM lookup, interpolation multiply, and the two-multiply rescale to Q3.13.
// Reset: synchronous rst_n clears all valid bits and range_mode; items in flight drop.
// The receiver cannot stall: each result strobe lasts exactly one cycle.
`include "table_atan2_unit_defines.svh"

module table_atan2_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [ta2_pkg::IN_W-1:0]   in_x_value,
  input  logic signed [ta2_pkg::IN_W-1:0]   in_y_value,
  output logic                              out_strobe,
  output logic signed [ta2_pkg::ANG_W-1:0]  out_angle,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ta2_pkg::ADDR_W-1:0]        paddr,
  input  logic [ta2_pkg::DATA_W-1:0]        pwdata,
  output logic [ta2_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  logic range_mode_r;
  logic cfg_hit;

  logic                                   in_vld_r;
  logic signed [ta2_pkg::IN_W-1:0]        in_x_r, in_y_r;
  logic [ta2_pkg::IN_W-1:0]               ax, ay;
  ta2_pkg::meta_t                         mm_meta_nxt;

  logic                                   mm_vld_r;
  logic [ta2_pkg::IN_W-1:0]               mn_r, mx_r;
  ta2_pkg::meta_t                         mm_meta_r;

  logic                                   dv_vld;
  logic [ta2_pkg::Z_W-1:0]                dv_z;
  ta2_pkg::meta_t                         dv_meta;

  logic [ta2_pkg::A_W-1:0]                t_a;
  logic [ta2_pkg::IDX_RAW_W-1:0]          t_idx_raw;
  logic [ta2_pkg::ROM_IDX_W-1:0]          t_idx;
  ta2_pkg::tag_t                          t_tag_nxt;

  logic                                   t_vld_r;
  ta2_pkg::tag_t                          t_tag_r;
  logic [ta2_pkg::ROM_W-1:0]              t_lo_r, t_hi_r;
  logic [ta2_pkg::FRAC_W-1:0]             t_fr_r;

  logic [ta2_pkg::DIFF_W-1:0]             m_diff;
  logic [ta2_pkg::PROD_W-1:0]             m_prod_nxt;
  logic                                   m_vld_r;
  ta2_pkg::tag_t                          m_tag_r;
  logic [ta2_pkg::ROM_W-1:0]              m_lo_r;
  logic [ta2_pkg::PROD_W-1:0]             m_prod_r;

  logic [ta2_pkg::PROD_W-1:0]             v_rnd;
  logic [ta2_pkg::ROM_W-1:0]              v_val;
  logic                                   v_vld_r;
  ta2_pkg::tag_t                          v_tag_r;
  logic [ta2_pkg::U_W-1:0]                v_u_r;

  logic [ta2_pkg::U_HI_W+ta2_pkg::M_W-1:0] q_prod;
  logic                                   q_vld_r;
  ta2_pkg::tag_t                          q_tag_r;
  logic [ta2_pkg::U_W-1:0]                q_u_r;
  logic [ta2_pkg::BASE_W-1:0]             q_est_r;

  logic [ta2_pkg::U_W-1:0]                r_qd, r_full;
  logic                                   r_vld_r;
  ta2_pkg::tag_t                          r_tag_r;
  logic [ta2_pkg::R_W-1:0]                r_rem_r;
  logic [ta2_pkg::BASE_W-1:0]             r_est_r;

  logic [ta2_pkg::BASE_W-1:0]             b_base_nxt;
  logic                                   b_vld_r;
  ta2_pkg::meta_t                         b_meta_r;
  logic [ta2_pkg::BASE_W-1:0]             b_base_r;

  logic signed [ta2_pkg::ANG_IW-1:0]      o_base, o_ang;
  logic                                   out_strobe_r;
  logic signed [ta2_pkg::ANG_W-1:0]       out_angle_r;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[ta2_pkg::ADDR_W-1:2] == ta2_pkg::REG_RANGE_MODE);
  assign prdata  = cfg_hit ? {{(ta2_pkg::DATA_W-1){1'b0}}, range_mode_r} : '0;
  assign busy    = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_mode_r <= 1'b0;
    end else if (psel && penable && pwrite && cfg_hit) begin
      range_mode_r <= pwdata[0];
    end
  end

  // capture input
  always_ff @(posedge clk) begin
    in_x_r <= in_x_value;
    in_y_r <= in_y_value;
  end

  // magnitudes and octant flags
  always_comb begin
    ax = in_x_r[ta2_pkg::IN_W-1] ? (~in_x_r + 1'b1) : in_x_r;
    ay = in_y_r[ta2_pkg::IN_W-1] ? (~in_y_r + 1'b1) : in_y_r;
    mm_meta_nxt.zero = (ax == '0) && (ay == '0);
    mm_meta_nxt.gt   = ax > ay;
    mm_meta_nxt.xn   = in_x_r[ta2_pkg::IN_W-1];
    mm_meta_nxt.yn   = in_y_r[ta2_pkg::IN_W-1];
  end

  always_ff @(posedge clk) begin
    mn_r      <= (ay < ax) ? ay : ax;
    mx_r      <= (ay < ax) ? ax : ay;
    mm_meta_r <= mm_meta_nxt;
  end

  ta2_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (mm_vld_r),
    .in_mn    (mn_r),
    .in_mx    (mx_r),
    .in_meta  (mm_meta_r),
    .out_vld  (dv_vld),
    .out_z    (dv_z),
    .out_meta (dv_meta)
  );

  // table address, fraction and small-ratio path
  always_comb begin
    t_a       = {dv_z, {ta2_pkg::TS_LOG{1'b0}}} - ta2_pkg::A_W'(1 << (ta2_pkg::FRAC_W - 1));
    t_idx_raw = t_a[ta2_pkg::A_W-1:ta2_pkg::FRAC_W];
    if (t_idx_raw > ta2_pkg::IDX_RAW_W'(ta2_pkg::ROM_LAST - 1)) begin
      t_idx = ta2_pkg::ROM_IDX_W'(ta2_pkg::ROM_LAST - 1);
    end else begin
      t_idx = ta2_pkg::ROM_IDX_W'(t_idx_raw);
    end
    t_tag_nxt.meta = dv_meta;
    t_tag_nxt.tiny = dv_z < ta2_pkg::Z_W'(ta2_pkg::SMALL_LIM);
    t_tag_nxt.sval = ta2_pkg::BASE_W'((dv_z + ta2_pkg::Z_W'(4)) >> 3);
  end

  always_ff @(posedge clk) begin
    t_tag_r <= t_tag_nxt;
    t_lo_r  <= ta2_pkg::ATAN_ROM[t_idx];
    t_hi_r  <= ta2_pkg::ATAN_ROM[t_idx + 1'b1];
    t_fr_r  <= t_a[ta2_pkg::FRAC_W-1:0];
  end

  // interpolation product
  assign m_diff     = ta2_pkg::DIFF_W'(t_hi_r - t_lo_r);
  assign m_prod_nxt = m_diff * t_fr_r;

  always_ff @(posedge clk) begin
    m_tag_r  <= t_tag_r;
    m_lo_r   <= t_lo_r;
    m_prod_r <= m_prod_nxt;
  end

  // interpolated value, prescaled by 8192/512
  assign v_rnd = m_prod_r + ta2_pkg::PROD_W'(1 << (ta2_pkg::FRAC_W - 1));
  assign v_val = m_lo_r + ta2_pkg::ROM_W'(v_rnd[ta2_pkg::PROD_W-1:ta2_pkg::FRAC_W]);

  always_ff @(posedge clk) begin
    v_tag_r <= m_tag_r;
    v_u_r   <= {v_val, 4'b0000} + ta2_pkg::U_OFS;
  end

  // quotient estimate by reciprocal
  assign q_prod = v_u_r[ta2_pkg::U_W-1:ta2_pkg::U_SH] * ta2_pkg::RECIP_M;

  always_ff @(posedge clk) begin
    q_tag_r <= v_tag_r;
    q_u_r   <= v_u_r;
    q_est_r <= q_prod[ta2_pkg::EST_SH+ta2_pkg::BASE_W-1:ta2_pkg::EST_SH];
  end

  // remainder for correction
  assign r_qd   = q_est_r * ta2_pkg::DEN;
  assign r_full = q_u_r - r_qd;

  always_ff @(posedge clk) begin
    r_tag_r <= q_tag_r;
    r_est_r <= q_est_r;
    r_rem_r <= r_full[ta2_pkg::R_W-1:0];
  end

  // corrected base angle
  always_comb begin
    if (r_tag_r.tiny) begin
      b_base_nxt = r_tag_r.sval;
    end else if (r_rem_r >= ta2_pkg::DEN2_R) begin
      b_base_nxt = r_est_r + ta2_pkg::BASE_W'(2);
    end else if (r_rem_r >= ta2_pkg::DEN_R) begin
      b_base_nxt = r_est_r + ta2_pkg::BASE_W'(1);
    end else begin
      b_base_nxt = r_est_r;
    end
  end

  always_ff @(posedge clk) begin
    b_meta_r <= r_tag_r.meta;
    b_base_r <= b_base_nxt;
  end

  // octant fold and output range
  always_comb begin
    o_base = signed'({{(ta2_pkg::ANG_IW-ta2_pkg::BASE_W){1'b0}}, b_base_r});
    if (b_meta_r.zero) begin
      o_ang = '0;
    end else if (b_meta_r.gt) begin
      if (!b_meta_r.xn) begin
        o_ang = b_meta_r.yn ? -o_base : o_base;
      end else begin
        o_ang = b_meta_r.yn ? (o_base - ta2_pkg::PI_Q13) : (ta2_pkg::PI_Q13 - o_base);
      end
    end else begin
      if (!b_meta_r.yn) begin
        o_ang = b_meta_r.xn ? (ta2_pkg::HALF_PI_Q13 + o_base)
                            : (ta2_pkg::HALF_PI_Q13 - o_base);
      end else begin
        o_ang = b_meta_r.xn ? (-ta2_pkg::HALF_PI_Q13 - o_base)
                            : (o_base - ta2_pkg::HALF_PI_Q13);
      end
    end
    if (range_mode_r && o_ang[ta2_pkg::ANG_IW-1]) begin
      o_ang = o_ang + ta2_pkg::TWO_PI_Q13;
    end
  end

  always_ff @(posedge clk) begin
    out_angle_r <= o_ang[ta2_pkg::ANG_W-1:0];
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      mm_vld_r     <= 1'b0;
      t_vld_r      <= 1'b0;
      m_vld_r      <= 1'b0;
      v_vld_r      <= 1'b0;
      q_vld_r      <= 1'b0;
      r_vld_r      <= 1'b0;
      b_vld_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      in_vld_r     <= start && !busy;
      mm_vld_r     <= in_vld_r;
      t_vld_r      <= dv_vld;
      m_vld_r      <= t_vld_r;
      v_vld_r      <= m_vld_r;
      q_vld_r      <= v_vld_r;
      r_vld_r      <= q_vld_r;
      b_vld_r      <= r_vld_r;
      out_strobe_r <= b_vld_r;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_angle  = out_angle_r;

  `TA2_ASSERT_AFTER(a_origin_zero, start && !busy && in_x_value == 16'sd0 && in_y_value == 16'sd0, ta2_pkg::LATENCY, out_strobe && out_angle == 17'sd0, "origin must give angle zero")
  `TA2_ASSERT_AFTER(a_pos_y_axis, start && !busy && in_x_value == 16'sd0 && in_y_value > 16'sd0, ta2_pkg::LATENCY, out_strobe && out_angle == 17'sd12868, "positive y axis must give half pi")
  `TA2_ASSERT_NOW(a_angle_range, out_strobe, out_angle >= -17'sd25736 && out_angle <= 17'sd51472, "angle out of range")

endmodule
